// File: rtl/assert_macros.svh
// Assertion macros for the checker file of this project.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define CHK_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that is also checked across reset.
`define CHK_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/lrs_pkg.sv
`timescale 1ns / 1ps
// Types and constants of the LSD radix sort unit.
// No dependencies; imported by the top level and its checker.
package lrs_pkg;

  // Width of the key field on both stream ports.
  localparam int TDATA_W = 32;

  typedef enum logic [12:0] {
    ST_IDLE   = 13'b0000000000001,
    ST_CLEAR  = 13'b0000000000010,
    ST_CNT_RD = 13'b0000000000100,
    ST_CNT_CT = 13'b0000000001000,
    ST_CNT_WR = 13'b0000000010000,
    ST_PRE_RD = 13'b0000000100000,
    ST_PRE_WR = 13'b0000001000000,
    ST_SCT_RD = 13'b0000010000000,
    ST_SCT_CT = 13'b0000100000000,
    ST_SCT_WR = 13'b0001000000000,
    ST_OUT_RD = 13'b0010000000000,
    ST_OUT_LD = 13'b0100000000000,
    ST_OUT_HOLD = 13'b1000000000000
  } state_t;

endpackage

// File: rtl/lrs_ram.sv
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lrs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/lsd_radix_sort_unit.sv
`timescale 1ns / 1ps
// LSD radix sort unit. Loading accepts one key per cycle. After the beat with tlast, the
// n keys are sorted in ceil(min(KEY_BITS,32)/DIGIT_BITS) digit passes, then each key leaves
// as one beat, held while m_tready is low. Sorting time is set by the single digit-count RAM
// port: each key visits it in three sequential steps when counting and again when scattering.
// Reset (rst, synchronous) empties the key buffer and returns to loading; RAMs are not cleared.
module lsd_radix_sort_unit
  import lrs_pkg::*;
#(
  parameter int MAX_KEYS   = 64,
  parameter int KEY_BITS   = 32,
  parameter int DIGIT_BITS = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [31:0] key_in
  input  logic               s_tlast,   // last_in
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [31:0] sorted_key
  output logic               m_tlast    // last_out
);

  localparam int KEY_W = (KEY_BITS < TDATA_W) ? KEY_BITS : TDATA_W;
  localparam int AW    = $clog2(MAX_KEYS);
  localparam int CW    = $clog2(MAX_KEYS + 1);
  localparam int RADIX = 1 << DIGIT_BITS;
  localparam int SHW   = $clog2(KEY_W);

  state_t                state;
  logic [CW-1:0]         count;
  logic [AW-1:0]         nlast;
  logic [AW-1:0]         idx;
  logic [DIGIT_BITS-1:0] dig;
  logic [DIGIT_BITS-1:0] dreg;
  logic [CW-1:0]         acc;
  logic [KEY_W-1:0]      key_hold;
  logic [SHW-1:0]        shift;
  logic                  sel;
  logic [TDATA_W-1:0]    out_key;
  logic                  out_last;
  logic                  out_valid;

  logic                  in_beat;
  logic                  not_full;
  logic [KEY_W-1:0]      a_rdata;
  logic [KEY_W-1:0]      b_rdata;
  logic [KEY_W-1:0]      src_data;
  logic [KEY_W-1:0]      key_sh;
  logic [DIGIT_BITS-1:0] digit;
  logic                  a_we;
  logic                  b_we;
  logic                  sct_we;
  logic [AW-1:0]         buf_waddr;
  logic [KEY_W-1:0]      buf_wdata;
  logic                  c_we;
  logic [DIGIT_BITS-1:0] c_waddr;
  logic [CW-1:0]         c_wdata;
  logic [DIGIT_BITS-1:0] c_raddr;
  logic [CW-1:0]         c_rdata;
  logic [CW-1:0]         pos;
  logic [CW-1:0]         sum;
  logic                  last_pass;

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = out_key;
  assign m_tlast  = out_last;

  assign in_beat  = s_tvalid && s_tready;
  assign not_full = (count < CW'(MAX_KEYS));

  // sel low: buffer A is the source of the current pass, B the destination.
  assign src_data = sel ? b_rdata : a_rdata;
  assign key_sh   = src_data >> shift;
  assign digit    = key_sh[DIGIT_BITS-1:0];
  assign pos      = CW'(c_rdata - 1'b1);
  assign sum      = CW'(acc + c_rdata);
  assign last_pass = ((SHW+1)'(shift) + (SHW+1)'(DIGIT_BITS)) >= (SHW+1)'(KEY_W);

  assign sct_we    = (state == ST_SCT_WR);
  assign a_we      = (in_beat && not_full) || (sct_we && sel);
  assign b_we      = sct_we && !sel;
  assign buf_waddr = (state == ST_IDLE) ? count[AW-1:0] : pos[AW-1:0];
  assign buf_wdata = (state == ST_IDLE) ? s_tdata[KEY_W-1:0] : key_hold;

  always_comb begin
    c_we    = 1'b0;
    c_waddr = dig;
    c_wdata = '0;
    c_raddr = dig;
    case (state)
      ST_CLEAR: begin
        c_we = 1'b1;
      end
      ST_CNT_CT, ST_SCT_CT: begin
        c_raddr = digit;
      end
      ST_CNT_WR: begin
        c_we    = 1'b1;
        c_waddr = dreg;
        c_wdata = CW'(c_rdata + 1'b1);
      end
      ST_PRE_WR: begin
        c_we    = 1'b1;
        c_wdata = sum;
      end
      ST_SCT_WR: begin
        c_we    = 1'b1;
        c_waddr = dreg;
        c_wdata = pos;
      end
      default: begin
        c_we = 1'b0;
      end
    endcase
  end

  lrs_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_buf_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (idx),
    .rdata (a_rdata)
  );

  lrs_ram #(.WIDTH(KEY_W), .DEPTH(MAX_KEYS)) u_buf_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (buf_waddr),
    .wdata (buf_wdata),
    .raddr (idx),
    .rdata (b_rdata)
  );

  lrs_ram #(.WIDTH(CW), .DEPTH(RADIX)) u_counts (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_beat) begin
            if (not_full) begin
              count <= CW'(count + 1'b1);
            end
            if (s_tlast) begin
              nlast <= not_full ? count[AW-1:0] : AW'(MAX_KEYS - 1);
              sel   <= 1'b0;
              shift <= '0;
              dig   <= '0;
              state <= ST_CLEAR;
            end
          end
        end
        ST_CLEAR: begin
          dig <= DIGIT_BITS'(dig + 1'b1);
          if (dig == '1) begin
            idx   <= '0;
            state <= ST_CNT_RD;
          end
        end
        ST_CNT_RD: begin
          state <= ST_CNT_CT;
        end
        ST_CNT_CT: begin
          dreg  <= digit;
          state <= ST_CNT_WR;
        end
        ST_CNT_WR: begin
          if (idx == nlast) begin
            acc   <= '0;
            state <= ST_PRE_RD;
          end else begin
            idx   <= AW'(idx + 1'b1);
            state <= ST_CNT_RD;
          end
        end
        ST_PRE_RD: begin
          state <= ST_PRE_WR;
        end
        ST_PRE_WR: begin
          acc <= sum;
          dig <= DIGIT_BITS'(dig + 1'b1);
          if (dig == '1) begin
            idx   <= nlast;
            state <= ST_SCT_RD;
          end else begin
            state <= ST_PRE_RD;
          end
        end
        ST_SCT_RD: begin
          state <= ST_SCT_CT;
        end
        ST_SCT_CT: begin
          dreg     <= digit;
          key_hold <= src_data;
          state    <= ST_SCT_WR;
        end
        ST_SCT_WR: begin
          // Keys are scattered from the back so that equal digits keep their order.
          if (idx == '0) begin
            sel <= !sel;
            if (last_pass) begin
              state <= ST_OUT_RD;
            end else begin
              shift <= SHW'(shift + DIGIT_BITS);
              state <= ST_CLEAR;
            end
          end else begin
            idx   <= AW'(idx - 1'b1);
            state <= ST_SCT_RD;
          end
        end
        ST_OUT_RD: begin
          state <= ST_OUT_LD;
        end
        ST_OUT_LD: begin
          out_key   <= TDATA_W'(src_data);
          out_last  <= (idx == nlast);
          out_valid <= 1'b1;
          state     <= ST_OUT_HOLD;
        end
        ST_OUT_HOLD: begin
          if (m_tready) begin
            out_valid <= 1'b0;
            if (out_last) begin
              count <= '0;
              state <= ST_IDLE;
            end else begin
              idx   <= AW'(idx + 1'b1);
              state <= ST_OUT_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: rtl/lrs_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the LSD radix sort unit, bound to the top level.
// Depends on lrs_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lrs_chk
  import lrs_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic [TDATA_W-1:0] s_tdata,   // [31:0] key_in
  input logic               s_tlast,   // last_in
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,   // [31:0] sorted_key
  input logic               m_tlast    // last_out
);

  `CHK_ASSERT_NR(a_reset_idle, clk, $past(rst) |-> s_tready && !m_tvalid, "not idle after reset")
  `CHK_ASSERT(a_no_overlap, clk, rst, !(s_tready && m_tvalid), "loading while emitting")
  `CHK_ASSERT(a_last_starts_sort, clk, rst, s_tvalid && s_tready && s_tlast |=> !s_tready, "input still open after last beat")
  `CHK_ASSERT(a_more_to_come, clk, rst, m_tvalid && m_tready && !m_tlast |=> !s_tready, "input reopened before final sorted beat")
  `CHK_ASSERT(a_out_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output beat changed")

endmodule

bind lsd_radix_sort_unit lrs_chk u_lrs_chk (.*);

// File: bench/testbench.sv
`timescale 1ns / 1ps
// Testbench for lsd_radix_sort_unit: loads key sets over the input stream and checks every
// sorted beat against a counting-sort predictor kept in step with the accepted keys.
// Depends on lrs_pkg and lsd_radix_sort_unit; stands alone otherwise.
module testbench;
  import lrs_pkg::TDATA_W;

  localparam int MAX_KEYS   = 64;
  localparam int KEY_BITS   = 32;
  localparam int DIGIT_BITS = 4;
  localparam int RADIX      = 1 << DIGIT_BITS;

  typedef struct packed {
    logic [TDATA_W-1:0] key;
    logic               last;
  } sorted_beat_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [TDATA_W-1:0] s_tdata = '0;
  logic               s_tlast = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic               m_tlast;

  // Keys held by the block for the set being loaded, and the sorted beats still owed.
  logic [TDATA_W-1:0] held_keys[$];
  sorted_beat_t       sorted_due[$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int error_count   = 0;
  int keys_sent     = 0;
  int sets_sorted   = 0;
  int largest_set   = 0;
  int dropped_keys  = 0;

  lsd_radix_sort_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Stable LSD counting sort of the held set, one pass per digit, scattering from the back.
  function automatic void sort_held_set();
    logic [TDATA_W-1:0] src [MAX_KEYS];
    logic [TDATA_W-1:0] dst [MAX_KEYS];
    int unsigned        tally [RADIX];
    logic [DIGIT_BITS-1:0] dig;
    int n, i, j, shift;
    n = held_keys.size();
    for (i = 0; i < n; i++) src[i] = held_keys[i];
    for (shift = 0; shift < KEY_BITS; shift += DIGIT_BITS) begin
      for (j = 0; j < RADIX; j++) tally[j] = 0;
      for (i = 0; i < n; i++) tally[src[i][shift +: DIGIT_BITS]]++;
      for (j = 1; j < RADIX; j++) tally[j] += tally[j-1];
      for (i = n - 1; i >= 0; i--) begin
        dig = src[i][shift +: DIGIT_BITS];
        tally[dig]--;
        dst[tally[dig]] = src[i];
      end
      src = dst;
    end
    for (i = 0; i < n; i++) sorted_due.push_back('{key: src[i], last: (i == n - 1)});
    sets_sorted++;
    if (n > largest_set) largest_set = n;
    held_keys.delete();
  endfunction

  // Called right after an accepted input beat.
  function automatic void load_key(logic [TDATA_W-1:0] key, logic last);
    if (held_keys.size() < MAX_KEYS) held_keys.push_back(key);
    else dropped_keys++;
    if (last) sort_held_set();
  endfunction

  // Sends one key; entered just after a rising edge and returns just after its handshake.
  task automatic send_key(input logic [TDATA_W-1:0] key, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= key;
    s_tlast  <= last;
    // The ready level is taken as it stood at the edge, before the block updates.
    @(posedge clk iff s_tready);
    load_key(key, last);
    keys_sent++;
  endtask

  // Holds the input side quiet until every owed beat has left the block.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sorted_due.size() != 0);
  endtask

  // Output side: random back-pressure and the comparison of each beat.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
    if (!rst && m_tvalid && m_tready) begin
      if (sorted_due.size() == 0) begin
        $display("%0t: unexpected beat key=%h last=%0b", $time, m_tdata, m_tlast);
        error_count++;
      end else begin
        sorted_beat_t want;
        want = sorted_due.pop_front();
        if (m_tdata !== want.key) begin
          $display("%0t: key mismatch expected %h actual %h", $time, want.key, m_tdata);
          error_count++;
        end
        if (m_tlast !== want.last) begin
          $display("%0t: last mismatch expected %0b actual %0b", $time, want.last, m_tlast);
          error_count++;
        end
      end
    end
  end

  task automatic send_set(input logic [TDATA_W-1:0] keys[$]);
    int i;
    for (i = 0; i < keys.size(); i++) send_key(keys[i], i == keys.size() - 1);
  endtask

  // Single-key sets at both extremes, then a set of edge patterns with a duplicate.
  task automatic test_directed();
    logic [TDATA_W-1:0] keys[$];
    keys = '{32'hFFFF_FFFF};
    send_set(keys);
    keys = '{32'h0000_0000};
    send_set(keys);
    keys = '{32'hFFFF_FFFF, 32'h0000_0000, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF,
             32'h0000_000F, 32'hF000_0000, 32'h0000_000F, 32'h0000_0010, 32'h1000_0000,
             32'h1234_5678, 32'h8765_4321};
    send_set(keys);
    // Keys that differ in one digit each, sent in descending order.
    keys = '{32'h0010_0000, 32'h0001_0000, 32'h0000_1000, 32'h0000_0100, 32'h0000_0010,
             32'h0000_0001};
    send_set(keys);
    wait_drained();
  endtask

  // A set that fills the buffer exactly, then one whose tail keys are dropped while its tlast still ends the set.
  task automatic test_buffer_full();
    int i;
    for (i = 0; i < MAX_KEYS; i++) send_key($urandom(), i == MAX_KEYS - 1);
    for (i = 0; i < MAX_KEYS + 3; i++) send_key($urandom(), i == MAX_KEYS + 2);
    wait_drained();
  endtask

  function automatic logic [TDATA_W-1:0] pick_key(int flavor);
    case (flavor)
      0:       return $urandom_range(7) * 32'h1111_1111;   // heavy duplicates
      1:       return {8'($urandom_range(255)), 24'h0} >> ($urandom_range(3) * 8);
      2:       return 32'h1 << $urandom_range(31);
      default: return $urandom();
    endcase
  endfunction

  task automatic test_random(input int send_pct, input int recv_pct, input int item_goal);
    int start, size, flavor, i;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    start = keys_sent;
    while (keys_sent - start < item_goal) begin
      size   = ($urandom_range(19) == 0) ? $urandom_range(33, MAX_KEYS) : $urandom_range(1, 12);
      flavor = $urandom_range(5);
      for (i = 0; i < size; i++) send_key(pick_key(flavor), i == size - 1);
    end
    wait_drained();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_buffer_full();
    test_random(12, 75, 20);
    test_random(75, 12, 20);
    test_random(0, 0, 20);
    s_tvalid <= 1'b0;
    repeat (200) @(posedge clk);
    $display("Sorted %0d sets from %0d input beats, largest %0d keys, %0d keys dropped when full.",
             sets_sorted, keys_sent, largest_set, dropped_keys);
    $display("Pacing covered sender-idle, receiver-idle and back-to-back modes.");
    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
